### rtl/assert_macros.svh
// Assertion macros shared by the extended gcd block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define EGCD_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define EGCD_NEVER(label, cond, msg) \
    `EGCD_CHECK(label, !(cond), msg)

`endif

### rtl/egcd_pkg.sv
// Types and constants of the extended gcd block.
package egcd_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int COEFF_BITS   = 32;
    localparam int CNT_W        = $clog2(OPERAND_BITS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(OPERAND_BITS - 1);

    typedef struct packed {
        logic [OPERAND_BITS-1:0] operand_a;
        logic [OPERAND_BITS-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic [OPERAND_BITS-1:0]      divisor;
        logic signed [COEFF_BITS-1:0] coeff_s;
        logic signed [COEFF_BITS-1:0] coeff_t;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_UPD   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic update;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic rcur_zero;
        logic out_free;
    } t_status;

endpackage

### rtl/extended_gcd_bezout_core.sv
// Extended gcd core: gcd(a, b) with Bezout coefficients s, t such that a*s + b*t = gcd.
// Each Euclid step: a check state, the bit-serial divider, an update state.
// One item at a time; the next input is taken in the cycle after the result is registered.
// Synchronous active-low reset clears the sequencer and the output valid flag.
module extended_gcd_bezout_core
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_cmd    cmd;
    t_status status;

    egcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    egcd_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_beat   (i_in_beat),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

### rtl/egcd_ctrl.sv
// Sequencer for the Euclid steps: check, bit-serial divide, coefficient update.
`include "assert_macros.svh"

module egcd_ctrl
    import egcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.rcur_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `EGCD_CHECK(a_cnt_bound, (r_state == S_DIV) |-> (r_cnt <= DIV_LAST), "divide count overrun")
    `EGCD_CHECK(a_div_to_upd, (r_state == S_DIV && r_cnt == DIV_LAST) |=> (r_state == S_UPD),
        "divide did not end in update")

endmodule

### rtl/egcd_dpath.sv
// Remainder, quotient and coefficient registers with the restoring divider.
`include "assert_macros.svh"

module egcd_dpath
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_stall,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_beat o_out_beat
);

    localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    logic [OPERAND_BITS-1:0] r_rprev, r_rcur, r_rem, r_quo;
    logic [DATA_WIDTH-1:0]   r_sprev, r_scur, r_tprev, r_tcur, r_acc_s, r_acc_t;
    logic                    r_ovalid;
    t_out_beat               r_obeat;

    logic [OPERAND_BITS:0]   trial, diff;
    logic                    q_bit;
    logic [DATA_WIDTH-1:0]   n_acc_s, n_acc_t;
    logic [COEFF_BITS+DATA_WIDTH-1:0] s_ext, t_ext;

    // one quotient bit per cycle, MSB first; accumulators build q*s and q*t alongside
    always_comb begin
        trial   = {r_rem, r_quo[OPERAND_BITS-1]};
        diff    = trial - {1'b0, r_rcur};
        q_bit   = (trial >= {1'b0, r_rcur});
        n_acc_s = {r_acc_s[DATA_WIDTH-2:0], 1'b0} + (q_bit ? r_scur : '0);
        n_acc_t = {r_acc_t[DATA_WIDTH-2:0], 1'b0} + (q_bit ? r_tcur : '0);
        // sign-extend the wrapped coefficients, low bits go to the 32-bit fields
        s_ext   = {{COEFF_BITS{r_sprev[DATA_WIDTH-1]}}, r_sprev};
        t_ext   = {{COEFF_BITS{r_tprev[DATA_WIDTH-1]}}, r_tprev};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rprev <= i_in_beat.operand_a;
            r_rcur  <= i_in_beat.operand_b;
            r_sprev <= ONE;
            r_scur  <= '0;
            r_tprev <= '0;
            r_tcur  <= ONE;
        end
        if (i_cmd.start_div) begin
            r_rem   <= '0;
            r_quo   <= r_rprev;
            r_acc_s <= '0;
            r_acc_t <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem   <= q_bit ? diff[OPERAND_BITS-1:0] : trial[OPERAND_BITS-1:0];
            r_quo   <= {r_quo[OPERAND_BITS-2:0], 1'b0};
            r_acc_s <= n_acc_s;
            r_acc_t <= n_acc_t;
        end
        if (i_cmd.update) begin
            r_rprev <= r_rcur;
            r_rcur  <= r_rem;
            r_sprev <= r_scur;
            r_scur  <= r_sprev - r_acc_s;
            r_tprev <= r_tcur;
            r_tcur  <= r_tprev - r_acc_t;
        end
        if (i_cmd.publish) begin
            r_obeat.divisor <= r_rprev;
            r_obeat.coeff_s <= s_ext[COEFF_BITS-1:0];
            r_obeat.coeff_t <= t_ext[COEFF_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_status.rcur_zero = (r_rcur == '0);
    assign o_status.out_free  = !r_ovalid || !i_out_stall;
    assign o_out_valid        = r_ovalid;
    assign o_out_beat         = r_obeat;

    `EGCD_CHECK(a_rem_below_div, i_cmd.div_step |=> (r_rem < r_rcur), "remainder not reduced")
    `EGCD_NEVER(a_upd_zero_div, i_cmd.update && (r_rcur == '0), "update with zero divisor")
    `EGCD_NEVER(a_publish_busy, i_cmd.publish && r_ovalid && i_out_stall,
        "result overwrites a held beat")

endmodule

### sim/extended_gcd_bezout_core_test.sv
// Self-checking testbench for the extended gcd core: random stalls, long output hold-off.
`timescale 1ns / 1ps

module extended_gcd_bezout_core_test
    import egcd_pkg::*;
();

    localparam int DATA_WIDTH = 32;
    localparam logic [OPERAND_BITS-1:0] OPER_MAX = '1;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int RANDOM_PAIRS = 380;

    typedef struct {
        t_in_beat  operands;
        t_out_beat want;
    } t_gcd_expect;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;

    t_in_beat    pending_pairs[$];
    t_gcd_expect expected_gcds[$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          total_items = 0;
    int          send_gap = 0;
    int          recv_wait = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    logic        long_hold = 1'b0;

    extended_gcd_bezout_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    // wrap to DATA_WIDTH two's complement, sign-extend, keep the field width
    function automatic logic [COEFF_BITS-1:0] wrap_coeff(logic [63:0] v);
        logic [63:0] m;
        logic [63:0] w;
        m = (DATA_WIDTH >= 64) ? '1 : ((64'd1 << DATA_WIDTH) - 64'd1);
        w = v & m;
        if (DATA_WIDTH < 64 && w[DATA_WIDTH-1])
            w = w | ~m;
        return w[COEFF_BITS-1:0];
    endfunction

    // iterative Euclid, coefficients in 64-bit two's complement
    function automatic t_out_beat bezout_of(t_in_beat p);
        logic [63:0] r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
        t_out_beat res;
        r0 = 64'(p.operand_a);
        r1 = 64'(p.operand_b);
        s0 = 64'd1;
        s1 = 64'd0;
        t0 = 64'd0;
        t1 = 64'd1;
        while (r1 != 64'd0) begin
            q  = r0 / r1;
            rn = r0 - q * r1;
            sn = s0 - q * s1;
            tn = t0 - q * t1;
            r0 = r1;
            r1 = rn;
            s0 = s1;
            s1 = sn;
            t0 = t1;
            t1 = tn;
        end
        res.divisor = r0[OPERAND_BITS-1:0];
        res.coeff_s = wrap_coeff(s0);
        res.coeff_t = wrap_coeff(t0);
        return res;
    endfunction

    function automatic t_in_beat operand_pair(logic [OPERAND_BITS-1:0] a,
                                              logic [OPERAND_BITS-1:0] b);
        t_in_beat p;
        p.operand_a = a;
        p.operand_b = b;
        return p;
    endfunction

    function automatic t_in_beat random_pair();
        t_in_beat    p;
        int unsigned kind, g, fx, fy, fz, k;
        logic [OPERAND_BITS-1:0] tmp;
        kind = $urandom_range(0, 99);
        p.operand_a = OPERAND_BITS'($urandom);
        p.operand_b = OPERAND_BITS'($urandom);
        if (kind < 40) begin
            // full-width operands as drawn
        end else if (kind < 60) begin
            p.operand_a = p.operand_a >> $urandom_range(0, OPERAND_BITS - 1);
            p.operand_b = p.operand_b >> $urandom_range(0, OPERAND_BITS - 1);
        end else if (kind < 75) begin
            // shared factor, so the gcd is not trivially 1
            g = $urandom_range(1, 4096);
            p.operand_a = OPERAND_BITS'(g * $urandom_range(0, 500000));
            p.operand_b = OPERAND_BITS'(g * $urandom_range(0, 500000));
        end else if (kind < 85) begin
            // consecutive Fibonacci numbers: the longest step chains
            fx = 0;
            fy = 1;
            k = $urandom_range(1, 45);
            repeat (k) begin
                fz = fx + fy;
                fx = fy;
                fy = fz;
            end
            p.operand_a = OPERAND_BITS'(fy);
            p.operand_b = OPERAND_BITS'(fx);
            if ($urandom_range(0, 1)) begin
                tmp = p.operand_a;
                p.operand_a = p.operand_b;
                p.operand_b = tmp;
            end
        end else if (kind < 92) begin
            p.operand_b = p.operand_a;
        end else if (kind < 96) begin
            p.operand_b = '0;
        end else begin
            p.operand_a = '0;
        end
        return p;
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // sender
    always @(posedge i_clk) begin : driver
        logic fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            if (fire)
                expected_gcds.push_back(t_gcd_expect'{i_in_beat, bezout_of(i_in_beat)});
            if (!i_in_valid || fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    i_in_beat  <= pending_pairs.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = send_burst ? 0 : $urandom_range(0, 14);
                    if ($urandom_range(0, 15) == 0)
                        send_burst = !send_burst;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : monitor
        t_gcd_expect e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_gcds.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat: divisor %0d s %0d t %0d",
                        o_out_beat.divisor, o_out_beat.coeff_s, o_out_beat.coeff_t));
                end else begin
                    e = expected_gcds.pop_front();
                    if (o_out_beat.divisor !== e.want.divisor)
                        flag_mismatch($sformatf("(%0d,%0d) divisor %0d, expected %0d",
                            e.operands.operand_a, e.operands.operand_b,
                            o_out_beat.divisor, e.want.divisor));
                    if (o_out_beat.coeff_s !== e.want.coeff_s)
                        flag_mismatch($sformatf("(%0d,%0d) coeff_s %0d, expected %0d",
                            e.operands.operand_a, e.operands.operand_b,
                            o_out_beat.coeff_s, e.want.coeff_s));
                    if (o_out_beat.coeff_t !== e.want.coeff_t)
                        flag_mismatch($sformatf("(%0d,%0d) coeff_t %0d, expected %0d",
                            e.operands.operand_a, e.operands.operand_b,
                            o_out_beat.coeff_t, e.want.coeff_t));
                end
                recv_wait = recv_burst ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
            end else if (o_out_valid && i_out_stall && recv_wait > 0) begin
                recv_wait--;
            end
            i_out_stall <= long_hold || (recv_wait > 0);
        end
    end

    // long output hold-off: the core keeps its result and must stall the sender
    initial begin : hold_off
        wait (results_seen >= 40);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin : watchdog
        #(50_000_000);
        $display("[extended_gcd_bezout_core] ERROR");
        $finish;
    end

    initial begin : sequencer
        pending_pairs.push_back(operand_pair(0, 0));
        pending_pairs.push_back(operand_pair(12345, 0));
        pending_pairs.push_back(operand_pair(OPER_MAX, 0));
        pending_pairs.push_back(operand_pair(0, OPER_MAX));
        pending_pairs.push_back(operand_pair(0, 1));
        pending_pairs.push_back(operand_pair(1, 0));
        pending_pairs.push_back(operand_pair(1, 1));
        pending_pairs.push_back(operand_pair(OPER_MAX, OPER_MAX));
        pending_pairs.push_back(operand_pair(OPER_MAX, 1));
        pending_pairs.push_back(operand_pair(1, OPER_MAX));
        pending_pairs.push_back(operand_pair(OPER_MAX, OPER_MAX - 1));
        pending_pairs.push_back(operand_pair(1836311903, 1134903170));
        pending_pairs.push_back(operand_pair(1134903170, 1836311903));
        pending_pairs.push_back(operand_pair(31'h40000000, 31'h00C00000));
        pending_pairs.push_back(operand_pair(OPER_MAX, 31'h40000000));
        pending_pairs.push_back(operand_pair(240, 46));
        pending_pairs.push_back(operand_pair(46, 240));
        pending_pairs.push_back(operand_pair(17, 5));
        pending_pairs.push_back(operand_pair(35, 15));
        pending_pairs.push_back(operand_pair(31'h55555555, 31'h2AAAAAAA));
        pending_pairs.push_back(operand_pair(1000000007, 998244353));
        pending_pairs.push_back(operand_pair(6, 6));
        pending_pairs.push_back(operand_pair(3, 7));
        repeat (RANDOM_PAIRS) pending_pairs.push_back(random_pair());
        total_items = pending_pairs.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every beat sent must come back before the check closes
        while (results_seen < total_items)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[extended_gcd_bezout_core] OK");
        else
            $display("[extended_gcd_bezout_core] ERROR");
        $finish;
    end

endmodule
